### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also watches the reset cycles
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rbdd_pkg.sv
// ----------------------------------------------------------------------------
// rbdd_pkg
// Types and constants of the raw block delta decoder.
// ----------------------------------------------------------------------------
package rbdd_pkg;

  localparam int BLOCK_W     = 64;
  localparam int PIX_W       = 15;
  localparam int POS_W       = 13;
  localparam int DIM_W       = 14;
  localparam int CFG_IDX_W   = 4;
  localparam int SAMPLE_W    = 11;
  localparam int DELTA_W     = 7;
  localparam int DELTAS_W    = 98;   // block bits 127:30
  localparam int PIX_PER_BLK = 16;

  localparam int DEF_MAX_WIDTH   = 8192;
  localparam int DEF_MAX_HEIGHT  = 8192;
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int DIM_LIMIT       = 8192;

  localparam logic [DIM_W-1:0] ROW_WIDTH_RST = 14'd4096;
  localparam logic [DIM_W-1:0] ROW_COUNT_RST = 14'd2048;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 4'd1;

  localparam logic [12:0] LIN_KNEE   = 13'd4000;
  localparam logic [14:0] LIN_OFFSET = 15'd12000;

  // one classified block handed from front to back
  typedef struct packed {
    logic [DELTAS_W-1:0]   deltas;
    logic [SAMPLE_W-1:0]   vmax;
    logic [SAMPLE_W-1:0]   vmin;
    logic [3:0]            imax;
    logic [3:0]            imin;
    logic [2:0]            sh;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    logic                  last_img;
  } rbdd_desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rbdd_qstat_t;

endpackage

### hw/rtl/rbdd_if.sv
// ----------------------------------------------------------------------------
// rbdd channel interfaces
// Valid/ready channels for blocks, pixels and register writes.
// ----------------------------------------------------------------------------
interface rbdd_in_if import rbdd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] block_low;
  logic [BLOCK_W-1:0] block_high;
  modport source (output valid, output block_low, output block_high, input ready);
  modport sink (input valid, input block_low, input block_high, output ready);
endinterface

interface rbdd_out_if import rbdd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic [POS_W-1:0] row_index;
  logic [POS_W-1:0] column_index;
  logic             last_of_block;
  logic             last_of_image;
  modport source (output valid, output pixel_value, output row_index, output column_index,
                  output last_of_block, output last_of_image, input ready);
  modport sink (input valid, input pixel_value, input row_index, input column_index,
                input last_of_block, input last_of_image, output ready);
endinterface

interface rbdd_cfg_if import rbdd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DIM_W-1:0]     reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

### hw/rtl/rbdd_queue.sv
// ----------------------------------------------------------------------------
// rbdd_queue
// Short register queue of classified blocks between front and back.
// ----------------------------------------------------------------------------
module rbdd_queue import rbdd_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rbdd_desc_t  push_desc,
  input  logic        pop,
  output rbdd_desc_t  head_desc,
  output rbdd_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rbdd_desc_t    slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.valid = (count_r != '0);
  assign head_desc  = slot_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### hw/rtl/rbdd_front.sv
// ----------------------------------------------------------------------------
// rbdd_front
// Holds the size registers and the image position, takes blocks apart
// into header fields and shift, and queues them for the back end.
// ----------------------------------------------------------------------------
module rbdd_front import rbdd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  rbdd_in_if.sink     in_ch,
  rbdd_cfg_if.sink    cfg_ch,
  input  rbdd_qstat_t q_stat,
  output logic        push,
  output rbdd_desc_t  push_desc
);

  localparam int WCAP_A = (MAX_WIDTH / 32) * 32;
  localparam int WCAP   = (WCAP_A > DIM_LIMIT) ? DIM_LIMIT : WCAP_A;
  localparam int HCAP   = (MAX_HEIGHT > DIM_LIMIT) ? DIM_LIMIT : MAX_HEIGHT;

  logic [DIM_W-1:0] row_width_r, row_count_r;
  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;

  logic [DIM_W-1:0] wm, w, h;
  logic [DIM_W-1:0] col_a, row_a, row_b, step;
  logic [11:0]      range;
  logic [2:0]       sh;
  logic [SAMPLE_W-1:0] vmax, vmin;
  logic [127:0]     blk;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign push         = in_ch.valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      row_count_r <= ROW_COUNT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == REG_ROW_WIDTH) begin
        row_width_r <= cfg_ch.reg_data;
      end else if (cfg_ch.reg_index == REG_ROW_COUNT) begin
        row_count_r <= cfg_ch.reg_data;
      end
    end
  end

  // effective image size
  always_comb begin
    wm = row_width_r & 14'h3FE0;
    w  = (wm > DIM_W'(WCAP)) ? DIM_W'(WCAP) : wm;
    if (w < 14'd32) begin
      w = 14'd32;
    end
    h = (row_count_r > DIM_W'(HCAP)) ? DIM_W'(HCAP) : row_count_r;
    if (h == '0) begin
      h = 14'd1;
    end
  end

  // position of this block and of the next one
  always_comb begin
    col_a = {1'b0, col_r};
    row_a = {1'b0, row_r};
    if (col_a >= w) begin
      col_a = '0;
      row_a = row_a + 1'b1;
    end
    if (row_a >= h) begin
      row_a = '0;
    end
    // odd block closes the 32-column group
    step    = col_a[0] ? col_a + 14'd31 : col_a + 14'd1;
    row_b   = row_a;
    col_nxt = step[POS_W-1:0];
    if (step >= w) begin
      col_nxt = '0;
      row_b   = row_a + 1'b1;
      if (row_b >= h) begin
        row_b = '0;
      end
    end
    row_nxt = row_b[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // header and shift
  assign blk   = {in_ch.block_high, in_ch.block_low};
  assign vmax  = blk[10:0];
  assign vmin  = blk[21:11];
  assign range = {1'b0, vmax} - {1'b0, vmin};

  always_comb begin
    if (range[11] || range < 12'd128) begin
      sh = 3'd0;
    end else if (range < 12'd256) begin
      sh = 3'd1;
    end else if (range < 12'd512) begin
      sh = 3'd2;
    end else if (range < 12'd1024) begin
      sh = 3'd3;
    end else begin
      sh = 3'd4;
    end
  end

  always_comb begin
    push_desc.deltas   = blk[127:30];
    push_desc.vmax     = vmax;
    push_desc.vmin     = vmin;
    push_desc.imax     = blk[25:22];
    push_desc.imin     = blk[29:26];
    push_desc.sh       = sh;
    push_desc.row      = row_a[POS_W-1:0];
    push_desc.col      = col_a[POS_W-1:0];
    push_desc.last_img = (row_a == h - 1'b1) && (col_a == w - 14'd31);
  end

endmodule

### hw/rtl/rbdd_back.sv
// ----------------------------------------------------------------------------
// rbdd_back
// Walks the sixteen pixels of one queued block, rebuilding and linearizing
// one pixel per cycle into the output register while out_ch is not stalled.
// ----------------------------------------------------------------------------
module rbdd_back import rbdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rbdd_qstat_t q_stat,
  input  rbdd_desc_t  head_desc,
  output logic        pop,
  rbdd_out_if.source  out_ch
);

  rbdd_desc_t            cur_r;
  logic [DELTAS_W-1:0]   data_r, data_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  ov_r, ov_nxt;
  logic [PIX_W-1:0]      pix_r;
  logic [POS_W-1:0]      row_r, col_r;
  logic                  lblk_r, limg_r;

  logic                  adv, at_end, is_max, is_min;
  logic [11:0]           dsh, v;
  logic [12:0]           x;
  logic [PIX_W-1:0]      lin;

  assign adv    = busy_r && (!ov_r || out_ch.ready);
  assign at_end = (idx_r == 4'(PIX_PER_BLK - 1));
  assign pop    = q_stat.valid && (!busy_r || (adv && at_end));
  assign is_max = (idx_r == cur_r.imax);
  assign is_min = (idx_r == cur_r.imin);

  // max wins when both positions coincide
  always_comb begin
    dsh = 12'(data_r[DELTA_W-1:0]) << cur_r.sh;
    if (is_max) begin
      v = {1'b0, cur_r.vmax};
    end else if (is_min) begin
      v = {1'b0, cur_r.vmin};
    end else begin
      v = dsh + {1'b0, cur_r.vmin};
    end
    x   = {v, 1'b0};
    lin = (x < LIN_KNEE) ? {2'b00, x} : {x, 2'b00} - LIN_OFFSET;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    data_nxt = data_r;
    ov_nxt   = ov_r;
    if (adv) begin
      idx_nxt = idx_r + 1'b1;
      if (!is_max && !is_min) begin
        data_nxt = data_r >> DELTA_W;
      end
      if (at_end) begin
        busy_nxt = 1'b0;
      end
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      data_nxt = head_desc.deltas;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (pop) begin
      cur_r <= head_desc;
    end
    if (adv) begin
      pix_r  <= lin;
      row_r  <= cur_r.row;
      col_r  <= cur_r.col + {8'd0, idx_r, 1'b0};
      lblk_r <= at_end;
      limg_r <= at_end && cur_r.last_img;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.pixel_value   = pix_r;
  assign out_ch.row_index     = row_r;
  assign out_ch.column_index  = col_r;
  assign out_ch.last_of_block = lblk_r;
  assign out_ch.last_of_image = limg_r;

endmodule

### hw/rtl/raw_block_delta_decoder.sv
// Throughput: one pixel per cycle while out_ch is not stalled, set by the back end that
// rebuilds a single pixel each cycle; the front takes a block whenever the queue has room.
// Reset: synchronous, active low; clears position to row 0, column 0, sets row_width to
// 4096 and row_count to 2048, and empties the queue and output register.
// ----------------------------------------------------------------------------
// raw_block_delta_decoder
// Decodes 16-byte delta blocks into linearized pixels with image position.
// ----------------------------------------------------------------------------
module raw_block_delta_decoder import rbdd_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  rbdd_in_if.sink    in_ch,
  rbdd_out_if.source out_ch,
  rbdd_cfg_if.sink   cfg_ch
);

  rbdd_qstat_t q_stat;
  rbdd_desc_t  push_desc, head_desc;
  logic        push, pop;

  rbdd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  rbdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .stat      (q_stat)
  );

  rbdd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_desc (head_desc),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

### hw/rtl/rbdd_checker.sv
// ----------------------------------------------------------------------------
// rbdd_checker
// Port-level checks of reset, output hold, pixel count, block framing and column order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbdd_checker import rbdd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] column_index,
  input logic             last_of_block,
  input logic             last_of_image
);

  logic             in_acc, out_acc;
  logic [15:0]      owed_r;
  logic [3:0]       pix_cnt_r;
  logic [POS_W-1:0] prev_col_r;
  logic             mid_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r    <= '0;
      pix_cnt_r <= '0;
      mid_r     <= 1'b0;
    end else begin
      owed_r <= owed_r + (in_acc ? 16'(PIX_PER_BLK) : 16'd0) - (out_acc ? 16'd1 : 16'd0);
      if (out_acc) begin
        pix_cnt_r <= pix_cnt_r + 1'b1;
        mid_r     <= !last_of_block;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_col_r <= column_index;
    end
  end

  `ASSERT_CLK_RST(a_reset_quiet, !rst_n |=> !out_valid, "output valid right after reset")
  `ASSERT_CLK(a_hold, out_valid && !out_ready |=> out_valid, "output dropped while stalled")
  `ASSERT_CLK(a_no_extra, out_acc |-> owed_r != '0, "pixel without a pending block")
  `ASSERT_CLK(a_framing, out_acc |-> (last_of_block == (pix_cnt_r == 4'd15)) && (!last_of_image || last_of_block), "block framing broken")
  `ASSERT_CLK(a_stride, out_acc && mid_r |-> column_index == prev_col_r + 13'd2, "column stride broken")

endmodule

bind raw_block_delta_decoder rbdd_checker u_rbdd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .column_index  (out_ch.column_index),
  .last_of_block (out_ch.last_of_block),
  .last_of_image (out_ch.last_of_image)
);

### tb/rbdd_checker.sv
// ----------------------------------------------------------------------------
// tb_rbdd_checker
// Watches the block, pixel and register channels of the raw block delta
// decoder, decodes every accepted block into its sixteen expected pixels
// and compares each pixel word leaving the block against the oldest one.
// ----------------------------------------------------------------------------
module tb_rbdd_checker import rbdd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rbdd_in_if   in_ch,
  rbdd_out_if  out_ch,
  rbdd_cfg_if  cfg_ch,
  output int   error_count,
  output int   pixels_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             blk_end;
    logic             img_end;
  } pixel_t;

  pixel_t           expected_pixels[$];
  pixel_t           oldest;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int unsigned      next_col;
  int unsigned      cur_row;

  function automatic int unsigned active_width();
    int unsigned w;
    int unsigned cap;
    w = width_reg & 14'h3FE0;
    cap = DEF_MAX_WIDTH & ~32'd31;
    if (cap > DIM_LIMIT) cap = DIM_LIMIT;
    if (w > cap) w = cap;
    if (w < 32) w = 32;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    int unsigned cap;
    h = height_reg;
    cap = DEF_MAX_HEIGHT;
    if (cap > DIM_LIMIT) cap = DIM_LIMIT;
    if (h > cap) h = cap;
    if (h < 1) h = 1;
    return h;
  endfunction

  // deltas that run past bit 127 read as zero
  function automatic logic [6:0] delta_at(logic [127:0] blk, int unsigned pos);
    if (pos >= 128) return 7'd0;
    return 7'(blk >> pos);
  endfunction

  function automatic logic [PIX_W-1:0] linear_of(int unsigned v);
    int unsigned x;
    x = v << 1;
    if (x < int'(LIN_KNEE)) return PIX_W'(x);
    return PIX_W'(x * 4 - int'(LIN_OFFSET));
  endfunction

  task automatic decode_block(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] blk;
    int unsigned  w, h, vmax, vmin, imax, imin, sh, pos, v, nxt;
    int           span;
    logic         closing;
    pixel_t       p;
    blk  = {hi, lo};
    w    = active_width();
    h    = active_height();
    vmax = lo[10:0];
    vmin = lo[21:11];
    imax = lo[25:22];
    imin = lo[29:26];
    span = int'(vmax) - int'(vmin);
    sh   = 0;
    pos  = 30;
    // a position left over from a larger size moves on
    if (next_col >= w) begin
      next_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    // signed compare, min above max keeps the shift at zero
    while (sh < 4 && int'(128 << sh) <= span) sh++;
    closing = (cur_row == h - 1) && (next_col == w - 31);
    for (int i = 0; i < PIX_PER_BLK; i++) begin
      if (i == imax) begin
        v = vmax;
      end else if (i == imin) begin
        v = vmin;
      end else begin
        v = (32'(delta_at(blk, pos)) << sh) + vmin;
        pos += DELTA_W;
      end
      p.value   = linear_of(v);
      p.row     = POS_W'(cur_row);
      p.col     = POS_W'(next_col + 2 * i);
      p.blk_end = (i == PIX_PER_BLK - 1);
      p.img_end = (i == PIX_PER_BLK - 1) && closing;
      expected_pixels.push_back(p);
    end
    // even block steps to the odd half, odd block to the next group
    nxt = (next_col & 1) ? next_col + 31 : next_col + 1;
    if (nxt >= w) begin
      nxt = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
    next_col = nxt & 32'h1FFF;
  endtask

  function automatic void check_field(string name, int unsigned want, logic [31:0] got);
    if (got !== 32'(want)) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_pixels.delete();
      width_reg  = ROW_WIDTH_RST;
      height_reg = ROW_COUNT_RST;
      next_col   = 0;
      cur_row    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.reg_index == REG_ROW_WIDTH) width_reg = cfg_ch.reg_data;
        else if (cfg_ch.reg_index == REG_ROW_COUNT) height_reg = cfg_ch.reg_data;
      end
      if (in_ch.valid && in_ch.ready) decode_block(in_ch.block_low, in_ch.block_high);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel word with nothing expected: value %0d row %0d column %0d",
                 out_ch.pixel_value, out_ch.row_index, out_ch.column_index);
          error_count++;
        end else begin
          oldest = expected_pixels.pop_front();
          check_field("pixel_value", 32'(oldest.value), 32'(out_ch.pixel_value));
          check_field("row_index", 32'(oldest.row), 32'(out_ch.row_index));
          check_field("column_index", 32'(oldest.col), 32'(out_ch.column_index));
          check_field("last_of_block", 32'(oldest.blk_end), 32'(out_ch.last_of_block));
          check_field("last_of_image", 32'(oldest.img_end), 32'(out_ch.last_of_image));
        end
      end
    end
    pixels_due = expected_pixels.size();
  end

endmodule

### tb/tb_raw_block_delta_decoder.sv
// ----------------------------------------------------------------------------
// tb_raw_block_delta_decoder
// Feeds directed and random compressed blocks through the decoder under
// several image sizes, with random gaps and stalls on both channels and one
// long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_raw_block_delta_decoder import rbdd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PHASES       = 9;
  localparam int          PHASE_BLOCKS = 25;
  localparam int          LONG_STALL   = 200;
  localparam int          DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic clk;
  logic rst_n;
  bit   calm;            // no gaps on either side while set
  int   stall_requests;
  int   stalls_served;
  int   error_count;
  int   pixels_due;

  rbdd_in_if  in_ch();
  rbdd_out_if out_ch();
  rbdd_cfg_if cfg_ch();

  raw_block_delta_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tb_rbdd_checker pixel_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .error_count (error_count),
    .pixels_due  (pixels_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // pixel side: random hold-off per word, or one long stall on request
  initial begin : pixel_sink
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stalls_served < stall_requests) begin
        out_ch.ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stalls_served++;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.block_low  = lo;
    in_ch.block_high = hi;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // registers change only once every pixel has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    in_ch.valid = 1'b0;
    wait (pixels_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.reg_index = idx;
    cfg_ch.reg_data  = val;
    cfg_ch.valid     = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [63:0] with_header(logic [63:0] body, int unsigned vmax,
                                              int unsigned vmin, int unsigned imax,
                                              int unsigned imin);
    return {body[63:30], 4'(imin), 4'(imax), 11'(vmin), 11'(vmax)};
  endfunction

  task automatic send_random_block();
    logic [63:0] lo, hi;
    int unsigned vmin, vmax, span, imax, imin;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    // mostly ordered headers spread over every shift, the rest raw noise
    if ($urandom_range(0, 7) != 0) begin
      vmin = $urandom_range(0, 2047);
      span = $urandom_range(0, 2047) >> $urandom_range(0, 7);
      vmax = (vmin + span > 2047) ? 2047 : vmin + span;
      imax = $urandom_range(0, 15);
      imin = ($urandom_range(0, 9) == 0) ? imax : $urandom_range(0, 15);
      lo   = with_header(lo, vmax, vmin, imax, imin);
    end
    send_block(lo, hi);
  endtask

  initial begin : stimulus
    int unsigned widths [PHASES];
    int unsigned heights[PHASES];
    int unsigned spans  [8];
    widths  = '{32, 64, 0, 16383, 8192, 31, 96, 100, 4096};
    heights = '{1, 3, 0, 2, 8192, 16383, 2, 5, 2048};
    spans   = '{127, 128, 255, 256, 511, 512, 1023, 1024};
    rst_n            = 1'b0;
    calm             = 1'b0;
    stall_requests   = 0;
    stalls_served    = 0;
    in_ch.valid      = 1'b0;
    in_ch.block_low  = '0;
    in_ch.block_high = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_ROW_WIDTH;
    cfg_ch.reg_data  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed blocks at the reset size
    send_block('0, '0);
    send_block('1, '1);
    send_block(with_header('1, 2047, 0, 0, 15), '1);
    send_block(with_header({$urandom, $urandom}, 0, 2047, 3, 9), {$urandom, $urandom});
    foreach (spans[k]) send_block(with_header('1, 100 + spans[k], 100, 1, 2), '1);
    // equal positions: fifteen deltas, the last past the block
    send_block(with_header('1, 1500, 200, 7, 7), '1);
    send_block(with_header('1, 900, 100, 15, 15), '1);
    send_block(with_header({$urandom, $urandom}, 1800, 20, 15, 0), {$urandom, $urandom});
    // linearization knee
    send_block(with_header('0, 2000, 1999, 0, 1), '0);
    send_block(with_header('1, 2047, 2047, 4, 5), '1);
    repeat (3) send_random_block();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_ROW_WIDTH, DIM_W'(widths[ph]));
      write_reg(REG_ROW_COUNT, DIM_W'(heights[ph]));
      calm = (ph % 3 == 1) || (ph == 4);
      // hold the pixel side off while words keep coming
      if (ph == 4) stall_requests++;
      repeat (PHASE_BLOCKS) send_random_block();
    end

    in_ch.valid = 1'b0;
    wait (pixels_due == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
